/* rtl/core/efla_pkg.sv */
// Shared types and constants for the free-list heap allocator.
package efla_pkg;

  localparam logic [31:0] MIN_BLOCK     = 32'd24;
  localparam logic [31:0] CHUNK         = 32'd4096;
  localparam logic [31:0] TAG_MASK      = 32'h7;
  localparam logic [31:0] ALLOC_BIT     = 32'h1;
  localparam logic [31:0] WORD_BYTES    = 32'd4;
  localparam logic [31:0] DWORD_BYTES   = 32'd8;
  localparam logic [31:0] FIRST_PAYLOAD = 32'd16;
  localparam logic [31:0] INIT_BREAK    = 32'd4112;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OOM = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE,
    S_FF_RD, S_FF_HDR, S_FF_NXT,
    S_GROW, S_GR_W2, S_GR_W3, S_GR_RET,
    S_TK_A, S_TK_B, S_TK_C, S_TK_D, S_TK_E,
    S_FR_A, S_FR_B, S_FR_C, S_FR_D,
    S_MG_A, S_MG_B, S_MG_C, S_MG_D, S_MG_RM2, S_MG_T1, S_MG_T2,
    S_PU1, S_PU2, S_PU3,
    S_LR_A, S_LR_B, S_LR_C, S_LR_D,
    S_DONE
  } state_t;

  // Heap contents after reset, by word index.
  function automatic logic [31:0] init_word(input logic [31:0] idx);
    logic [31:0] v;
    v = '0;
    if (idx == 32'd1 || idx == 32'd2) v = DWORD_BYTES | ALLOC_BIT;
    if (idx == 32'd3 || idx == 32'd1026) v = CHUNK;
    if (idx == 32'd1027) v = ALLOC_BIT;
    return v;
  endfunction

endpackage

/* rtl/core/explicit_free_list_allocator.sv */
// Explicit free-list first-fit heap allocator with boundary tags.
//
//  channel | ports              | contents
//  in      | in_tvalid/in_tready | tuser: action; tdata: request_size, block_address
//  out     | out_tvalid/out_tready | tdata: result_address, status
//
// After reset the heap memory is swept once, one word a cycle, while no transaction
// is taken. A request then takes a sequence of memory steps: walking the free list
// node by node, growing the break, checking a free, taking a block (with a split),
// merging, unlinking list nodes and writing new tags; there is one step each to
// accept the request and to post the result.
// One request is in flight at a time; the next is taken once the previous result
// has left the output register.
module explicit_free_list_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] request_size, [31:16] block_address
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] result_address, [17:16] status
);
  import efla_pkg::*;

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int IW         = $clog2(HEAP_WORDS);
  localparam int GUARD_INIT = HEAP_BYTES / 24 + 2;
  localparam int GW         = $clog2(GUARD_INIT + 1);
  localparam logic [31:0] HEAP_LIM = 32'(HEAP_BYTES);

  logic [31:0] mem [HEAP_WORDS];

  state_t      state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        act_r, act_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] asize_r, asize_nxt;
  logic [31:0] head_r, head_nxt;
  logic [31:0] brk_r, brk_nxt;
  logic [31:0] bp_r, bp_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  logic [31:0] gsz_r, gsz_nxt;
  logic [31:0] tbp_r, tbp_nxt;
  logic [31:0] csize_r, csize_nxt;
  logic        split_r, split_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [31:0] mbp_r, mbp_nxt;
  logic [31:0] pfoot_r, pfoot_nxt;
  logic [31:0] msize_r, msize_nxt;
  logic [31:0] nb_r, nb_nxt;
  state_t      mg_ret_r, mg_ret_nxt;
  logic [31:0] lr_x_r, lr_x_nxt;
  logic [31:0] lr_p_r, lr_p_nxt;
  logic [31:0] lr_n_r, lr_n_nxt;
  state_t      lr_ret_r, lr_ret_nxt;
  logic [31:0] res_r, res_nxt;
  status_t     stat_r, stat_nxt;

  logic [31:0] rq_r;
  logic        rok_r;
  logic [31:0] rdata, raddr, waddr, wdata;
  logic        we;

  logic        in_acc, out_acc;
  logic [31:0] rsz, gsize, psize, tsz, fsize, tk_sz;
  logic        fit, split_c, prev_used, next_used, free_ok;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_valid_r && out_tready;
  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, stat_r, res_r[15:0]};

  assign rdata     = rok_r ? rq_r : '0;
  assign rsz       = rdata & ~TAG_MASK;
  assign fit       = asize_r <= rsz;
  assign split_c   = (rsz >= asize_r) && ((rsz - asize_r) >= MIN_BLOCK);
  assign gsize     = (asize_r > CHUNK) ? asize_r : CHUNK;
  assign psize     = pfoot_r & ~TAG_MASK;
  assign prev_used = pfoot_r[0] || (psize == '0);
  assign next_used = rdata[0];
  assign tk_sz     = split_r ? asize_r : csize_r;
  assign fsize     = hdr_r & ~TAG_MASK;
  assign tsz       = msize_r;
  assign free_ok   = (addr_r != '0) && (addr_r[2:0] == 3'd0) && (addr_r >= FIRST_PAYLOAD)
                     && hdr_r[0] && (fsize >= MIN_BLOCK)
                     && ((addr_r + fsize) <= brk_r) && (rdata == hdr_r);

  always_ff @(posedge clk) begin
    if (we && (waddr < HEAP_LIM)) begin
      mem[waddr[IW+1:2]] <= wdata;
    end
    rq_r  <= mem[raddr[IW+1:2]];
    rok_r <= raddr < HEAP_LIM;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (clr_r == IW'(HEAP_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) state_nxt = S_FR_A;
          else if (in_tdata[15:0] == 16'd0) state_nxt = S_DONE;
          else state_nxt = S_FF_RD;
        end
      end
      S_FF_RD:  state_nxt = (bp_r == '0 || guard_r == '0) ? S_GROW : S_FF_HDR;
      S_FF_HDR: state_nxt = rdata[0] ? S_GROW : (fit ? S_TK_A : S_FF_NXT);
      S_FF_NXT: state_nxt = S_FF_RD;
      S_GROW:   state_nxt = ((brk_r + gsize) > HEAP_LIM) ? S_DONE : S_GR_W2;
      S_GR_W2:  state_nxt = S_GR_W3;
      S_GR_W3:  state_nxt = S_MG_A;
      S_GR_RET: state_nxt = S_TK_A;
      S_TK_A:   state_nxt = S_TK_B;
      S_TK_B:   state_nxt = S_TK_C;
      S_TK_C:   state_nxt = S_LR_A;
      S_TK_D:   state_nxt = S_TK_E;
      S_TK_E:   state_nxt = S_MG_A;
      S_FR_A:   state_nxt = S_FR_B;
      S_FR_B:   state_nxt = S_FR_C;
      S_FR_C:   state_nxt = free_ok ? S_FR_D : S_DONE;
      S_FR_D:   state_nxt = S_MG_A;
      S_MG_A:   state_nxt = S_MG_B;
      S_MG_B:   state_nxt = S_MG_C;
      S_MG_C:   state_nxt = S_MG_D;
      S_MG_D:   state_nxt = (prev_used && next_used) ? S_PU1 : S_LR_A;
      S_MG_RM2: state_nxt = S_LR_A;
      S_MG_T1:  state_nxt = S_MG_T2;
      S_MG_T2:  state_nxt = S_PU1;
      S_PU1:    state_nxt = S_PU2;
      S_PU2:    state_nxt = S_PU3;
      S_PU3:    state_nxt = mg_ret_r;
      S_LR_A:   state_nxt = S_LR_B;
      S_LR_B:   state_nxt = S_LR_C;
      S_LR_C:   state_nxt = S_LR_D;
      S_LR_D:   state_nxt = lr_ret_r;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_acc;
    act_nxt   = act_r;   addr_nxt  = addr_r;  asize_nxt = asize_r;
    head_nxt  = head_r;  brk_nxt   = brk_r;   bp_nxt    = bp_r;
    guard_nxt = guard_r; gsz_nxt   = gsz_r;   tbp_nxt   = tbp_r;
    csize_nxt = csize_r; split_nxt = split_r; hdr_nxt   = hdr_r;
    mbp_nxt   = mbp_r;   pfoot_nxt = pfoot_r; msize_nxt = msize_r;
    nb_nxt    = nb_r;    mg_ret_nxt = mg_ret_r;
    lr_x_nxt  = lr_x_r;  lr_p_nxt  = lr_p_r;  lr_n_nxt  = lr_n_r;
    lr_ret_nxt = lr_ret_r;
    res_nxt   = res_r;   stat_nxt  = stat_r;
    raddr = '0;
    waddr = '0;
    wdata = '0;
    we    = 1'b0;
    case (state_r)
      S_INIT: begin
        we      = 1'b1;
        waddr   = {{(30 - IW){1'b0}}, clr_r, 2'b00};
        wdata   = init_word({{(32 - IW){1'b0}}, clr_r});
        clr_nxt = clr_r + IW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt   = in_tuser[0];
          addr_nxt  = {16'd0, in_tdata[31:16]};
          asize_nxt = (({16'd0, in_tdata[15:0]} + 32'd7) & ~TAG_MASK) + DWORD_BYTES;
          if ((({16'd0, in_tdata[15:0]} + 32'd7) & ~TAG_MASK) + DWORD_BYTES < MIN_BLOCK)
            asize_nxt = MIN_BLOCK;
          bp_nxt    = head_r;
          guard_nxt = GW'(GUARD_INIT);
          res_nxt   = '0;
          stat_nxt  = (!in_tuser[0] && in_tdata[15:0] == 16'd0) ? ST_BAD : ST_OK;
        end
      end
      S_FF_RD:  raddr = bp_r - WORD_BYTES;
      S_FF_HDR: begin
        tbp_nxt = bp_r;
        raddr   = bp_r + DWORD_BYTES;
      end
      S_FF_NXT: begin
        bp_nxt    = rdata;
        guard_nxt = guard_r - GW'(1);
      end
      S_GROW: begin
        gsz_nxt = gsize;
        if ((brk_r + gsize) > HEAP_LIM) begin
          stat_nxt = ST_OOM;
        end else begin
          we    = 1'b1;
          waddr = brk_r - WORD_BYTES;
          wdata = gsize;
        end
      end
      S_GR_W2: begin
        we    = 1'b1;
        waddr = brk_r + gsz_r - DWORD_BYTES;
        wdata = gsz_r;
      end
      S_GR_W3: begin
        we         = 1'b1;
        waddr      = brk_r + gsz_r - WORD_BYTES;
        wdata      = ALLOC_BIT;
        mbp_nxt    = brk_r;
        brk_nxt    = brk_r + gsz_r;
        mg_ret_nxt = S_GR_RET;
      end
      S_GR_RET: tbp_nxt = mbp_r;
      S_TK_A: begin
        if (state_r == S_TK_A && act_r == 1'b0) res_nxt = tbp_r;
        raddr = tbp_r - WORD_BYTES;
      end
      S_TK_B: begin
        csize_nxt = rsz;
        split_nxt = split_c;
        we        = 1'b1;
        waddr     = tbp_r - WORD_BYTES;
        wdata     = (split_c ? asize_r : rsz) | ALLOC_BIT;
      end
      S_TK_C: begin
        we         = 1'b1;
        waddr      = tbp_r + tk_sz - DWORD_BYTES;
        wdata      = tk_sz | ALLOC_BIT;
        lr_x_nxt   = tbp_r;
        lr_ret_nxt = split_r ? S_TK_D : S_DONE;
      end
      S_TK_D: begin
        we    = 1'b1;
        waddr = tbp_r + asize_r - WORD_BYTES;
        wdata = csize_r - asize_r;
      end
      S_TK_E: begin
        we         = 1'b1;
        waddr      = tbp_r + csize_r - DWORD_BYTES;
        wdata      = csize_r - asize_r;
        mbp_nxt    = tbp_r + asize_r;
        mg_ret_nxt = S_DONE;
      end
      S_FR_A: raddr = addr_r - WORD_BYTES;
      S_FR_B: begin
        hdr_nxt = rdata;
        raddr   = addr_r + rsz - DWORD_BYTES;
      end
      S_FR_C: begin
        if (!free_ok) begin
          stat_nxt = ST_BAD;
        end else begin
          we    = 1'b1;
          waddr = addr_r - WORD_BYTES;
          wdata = fsize;
        end
      end
      S_FR_D: begin
        we         = 1'b1;
        waddr      = addr_r + fsize - DWORD_BYTES;
        wdata      = fsize;
        mbp_nxt    = addr_r;
        mg_ret_nxt = S_DONE;
      end
      S_MG_A: raddr = mbp_r - DWORD_BYTES;
      S_MG_B: begin
        pfoot_nxt = rdata;
        raddr     = mbp_r - WORD_BYTES;
      end
      S_MG_C: begin
        msize_nxt = rsz;
        nb_nxt    = mbp_r + rsz;
        raddr     = mbp_r + rsz - WORD_BYTES;
      end
      S_MG_D: begin
        if (prev_used && !next_used) begin
          msize_nxt  = msize_r + rsz;
          lr_x_nxt   = nb_r;
          lr_ret_nxt = S_MG_T1;
        end else if (!prev_used && next_used) begin
          msize_nxt  = msize_r + psize;
          mbp_nxt    = mbp_r - psize;
          lr_x_nxt   = mbp_r - psize;
          lr_ret_nxt = S_MG_T1;
        end else if (!prev_used && !next_used) begin
          msize_nxt  = msize_r + psize + rsz;
          mbp_nxt    = mbp_r - psize;
          lr_x_nxt   = mbp_r - psize;
          lr_ret_nxt = S_MG_RM2;
        end
      end
      S_MG_RM2: begin
        lr_x_nxt   = nb_r;
        lr_ret_nxt = S_MG_T1;
      end
      S_MG_T1: begin
        we    = 1'b1;
        waddr = mbp_r - WORD_BYTES;
        wdata = tsz;
      end
      S_MG_T2: begin
        we    = 1'b1;
        waddr = mbp_r + tsz - DWORD_BYTES;
        wdata = tsz;
      end
      S_PU1: begin
        we    = 1'b1;
        waddr = mbp_r + DWORD_BYTES;
        wdata = head_r;
      end
      S_PU2: begin
        we    = 1'b1;
        waddr = mbp_r;
        wdata = '0;
      end
      S_PU3: begin
        we       = head_r != '0;
        waddr    = head_r;
        wdata    = mbp_r;
        head_nxt = mbp_r;
      end
      S_LR_A: raddr = lr_x_r;
      S_LR_B: begin
        lr_p_nxt = rdata;
        raddr    = lr_x_r + DWORD_BYTES;
      end
      S_LR_C: begin
        lr_n_nxt = rdata;
        if (lr_p_r != '0) begin
          we    = 1'b1;
          waddr = lr_p_r + DWORD_BYTES;
          wdata = rdata;
        end else begin
          head_nxt = rdata;
        end
      end
      S_LR_D: begin
        we    = lr_n_r != '0;
        waddr = lr_n_r;
        wdata = lr_p_r;
      end
      S_DONE: out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      head_r      <= FIRST_PAYLOAD;
      brk_r       <= INIT_BREAK;
      mg_ret_r    <= S_DONE;
      lr_ret_r    <= S_DONE;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      brk_r       <= brk_nxt;
      mg_ret_r    <= mg_ret_nxt;
      lr_ret_r    <= lr_ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;   addr_r  <= addr_nxt;  asize_r <= asize_nxt;
    bp_r    <= bp_nxt;    guard_r <= guard_nxt; gsz_r   <= gsz_nxt;
    tbp_r   <= tbp_nxt;   csize_r <= csize_nxt; split_r <= split_nxt;
    hdr_r   <= hdr_nxt;   mbp_r   <= mbp_nxt;   pfoot_r <= pfoot_nxt;
    msize_r <= msize_nxt; nb_r    <= nb_nxt;
    lr_x_r  <= lr_x_nxt;  lr_p_r  <= lr_p_nxt;  lr_n_r  <= lr_n_nxt;
    res_r   <= res_nxt;   stat_r  <= stat_nxt;
  end

endmodule

/* sim/tb.sv */
// Testbench for the free-list heap allocator: directed and random request streams checked against a heap model.
module tb;
  import efla_pkg::*;

  localparam int HEAP_BYTES = 65536;
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  explicit_free_list_allocator #(.HEAP_BYTES(HEAP_BYTES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic        is_free;
    logic [15:0] req_size;
    logic [15:0] addr;
  } request_t;

  typedef struct packed {
    logic [15:0] addr;
    status_t     status;
  } outcome_t;

  request_t pending_q[$];
  outcome_t expected_q[$];
  logic [15:0] live_q[$];

  logic [31:0] heap_mem [HEAP_WORDS];
  logic [31:0] list_head;
  logic [31:0] brk;
  int errors = 0;
  int n_allocs = 0, n_frees = 0, n_oom = 0, n_bad = 0, n_results = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_cnt = 0;
  bit hold_out = 1'b0;
  bit hold_done = 1'b0;
  bit drain_req = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] mrd(logic [31:0] a);
    return (a / 4 < HEAP_WORDS) ? heap_mem[a[15:2]] : 32'd0;
  endfunction

  function automatic void mwr(logic [31:0] a, logic [31:0] v);
    if (a / 4 < HEAP_WORDS) heap_mem[a[15:2]] = v;
  endfunction

  function automatic void unlink(logic [31:0] bp);
    logic [31:0] p, n;
    p = mrd(bp);
    n = mrd(bp + 8);
    if (p != 0) mwr(p + 8, n);
    else list_head = n;
    if (n != 0) mwr(n, p);
  endfunction

  function automatic void push_front(logic [31:0] bp);
    mwr(bp + 8, list_head);
    mwr(bp, 0);
    if (list_head != 0) mwr(list_head, bp);
    list_head = bp;
  endfunction

  function automatic void tag(logic [31:0] bp, logic [31:0] sz, logic [31:0] al);
    mwr(bp - 4, sz | al);
    mwr(bp + sz - 8, sz | al);
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic [31:0] pf, ps, sz, nb;
    bit pu, nu;
    pf = mrd(bp - 8);
    ps = pf & ~TAG_MASK;
    pu = ((pf & ALLOC_BIT) != 0) || ps == 0;
    sz = mrd(bp - 4) & ~TAG_MASK;
    nb = bp + sz;
    nu = (mrd(nb - 4) & ALLOC_BIT) != 0;
    if (pu && !nu) begin
      sz += mrd(nb - 4) & ~TAG_MASK;
      unlink(nb);
      tag(bp, sz, 0);
    end else if (!pu && nu) begin
      sz += ps;
      bp -= ps;
      unlink(bp);
      tag(bp, sz, 0);
    end else if (!pu && !nu) begin
      sz += ps + (mrd(nb - 4) & ~TAG_MASK);
      unlink(bp - ps);
      unlink(nb);
      bp -= ps;
      tag(bp, sz, 0);
    end
    push_front(bp);
    return bp;
  endfunction

  function automatic logic [31:0] search_fit(logic [31:0] asz);
    logic [31:0] bp;
    int guard;
    bp = list_head;
    guard = HEAP_BYTES / 24 + 2;
    while (bp != 0 && guard != 0) begin
      if ((mrd(bp - 4) & ALLOC_BIT) != 0) return 0;
      if (asz <= (mrd(bp - 4) & ~TAG_MASK)) return bp;
      bp = mrd(bp + 8);
      guard--;
    end
    return 0;
  endfunction

  function automatic void place(logic [31:0] bp, logic [31:0] asz);
    logic [31:0] cs;
    cs = mrd(bp - 4) & ~TAG_MASK;
    if (cs >= asz && cs - asz >= MIN_BLOCK) begin
      tag(bp, asz, ALLOC_BIT);
      unlink(bp);
      tag(bp + asz, cs - asz, 0);
      void'(coalesce(bp + asz));
    end else begin
      tag(bp, cs, ALLOC_BIT);
      unlink(bp);
    end
  endfunction

  function automatic logic [31:0] extend(logic [31:0] sz);
    logic [31:0] bp;
    bp = brk;
    if (bp + sz > HEAP_BYTES) return 0;
    tag(bp, sz, 0);
    mwr(bp + sz - 4, ALLOC_BIT);
    brk = bp + sz;
    return coalesce(bp);
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < HEAP_WORDS; i++) heap_mem[i] = init_word(i);
    list_head = FIRST_PAYLOAD;
    brk = INIT_BREAK;
  endfunction

  function automatic outcome_t serve(request_t r);
    outcome_t o;
    logic [31:0] asz, bp, hdr, sz, a;
    o.addr = '0;
    o.status = ST_OK;
    if (!r.is_free) begin
      if (r.req_size == 0) o.status = ST_BAD;
      else begin
        asz = ((32'(r.req_size) + 7) & ~TAG_MASK) + DWORD_BYTES;
        if (asz < MIN_BLOCK) asz = MIN_BLOCK;
        bp = search_fit(asz);
        if (bp == 0) bp = extend(asz > CHUNK ? asz : CHUNK);
        if (bp == 0) o.status = ST_OOM;
        else begin
          place(bp, asz);
          o.addr = bp[15:0];
        end
      end
    end else begin
      a = 32'(r.addr);
      hdr = mrd(a - 4);
      sz = hdr & ~TAG_MASK;
      if (a == 0 || (a & TAG_MASK) != 0 || a < FIRST_PAYLOAD || (hdr & ALLOC_BIT) == 0 ||
          sz < MIN_BLOCK || a + sz > brk || mrd(a + sz - 8) != hdr) o.status = ST_BAD;
      else begin
        tag(a, sz, 0);
        void'(coalesce(a));
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) in_tvalid <= 1'b0;
    else if (in_tvalid && in_tready) begin
      r = '{in_tuser[0], in_tdata[15:0], in_tdata[31:16]};
      expected_q.push_back(serve(r));
      in_gap <= $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
      in_tvalid <= 1'b0;
    end else if (!in_tvalid && !drain_req && pending_q.size() != 0) begin
      if (in_gap != 0) in_gap <= in_gap - 1;
      else begin
        r = pending_q.pop_front();
        in_tuser <= r.is_free;
        in_tdata <= {r.addr, r.req_size};
        in_tvalid <= 1'b1;
      end
    end
  end

  // monitor / receiver
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (expected_q.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          e = expected_q.pop_front();
          if (out_tdata[15:0] != e.addr)
            report_mismatch("result_address", out_tdata[15:0], e.addr);
          if (out_tdata[17:16] != e.status)
            report_mismatch("status", out_tdata[17:16], e.status);
          if (out_tdata[23:18] != 0) report_mismatch("pad bits", out_tdata[23:18], 0);
          if (e.status == ST_OOM) n_oom++;
          else if (e.status == ST_BAD) n_bad++;
          else if (e.addr != 0) begin
            n_allocs++;
            live_q.push_back(e.addr);
          end else n_frees++;
        end
        out_gap <= $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
        out_tready <= 1'b0;
      end else if (hold_out && !hold_done) begin
        out_tready <= 1'b0;
        if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end else if (out_gap != 0) out_gap <= out_gap - 1;
      else out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic request_t mk_alloc(int sz);
    return '{1'b0, 16'(sz), 16'($urandom)};
  endfunction

  function automatic request_t mk_free(int a);
    return '{1'b1, 16'($urandom), 16'(a)};
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(negedge clk);
  endtask

  // frees mostly use addresses of live blocks, picked when the request is queued; some use bad addresses
  task automatic random_phase(int n, bit big);
    int k, sz;
    for (int i = 0; i < n; i++) begin
      while (pending_q.size() > 4) @(posedge clk);
      k = $urandom_range(0, 99);
      if (k < 45) begin
        sz = big ? $urandom_range(1, 65535) :
             ($urandom_range(0, 9) == 0 ? $urandom_range(1, 8000) : $urandom_range(1, 300));
        pending_q.push_back(mk_alloc(sz));
      end else if (k < 85 && live_q.size() != 0) begin
        sz = $urandom_range(0, live_q.size() - 1);
        pending_q.push_back(mk_free(live_q[sz]));
        live_q.delete(sz);
      end else if (k < 90) pending_q.push_back(mk_alloc(0));
      else if (k < 95) pending_q.push_back(mk_free($urandom_range(0, 65535)));
      else if (live_q.size() != 0)
        pending_q.push_back(mk_free(live_q[$urandom_range(0, live_q.size() - 1)] + 8));
      else pending_q.push_back(mk_free(0));
    end
  endtask

  initial begin
    heap_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    pending_q.push_back(mk_alloc(0));
    pending_q.push_back(mk_free(0));
    pending_q.push_back(mk_alloc(1));
    pending_q.push_back(mk_alloc(16));
    pending_q.push_back(mk_alloc(17));
    pending_q.push_back(mk_alloc(4088));
    pending_q.push_back(mk_alloc(65535));
    pending_q.push_back(mk_free(16));
    pending_q.push_back(mk_free(16));
    pending_q.push_back(mk_free(20));
    pending_q.push_back(mk_free(8));
    pending_q.push_back(mk_free(65535));
    pending_q.push_back(mk_free(65528));
    pending_q.push_back(mk_free(40));
    pending_q.push_back(mk_free(72));
    pending_q.push_back(mk_alloc(30000));
    pending_q.push_back(mk_alloc(30000));
    pending_q.push_back(mk_alloc(200));
    pending_q.push_back('{1'b1, 16'hFFFF, 16'h0000});
    pending_q.push_back('{1'b0, 16'h5555, 16'hFFFF});
    wait_drained();
    live_q.delete();

    // long receiver stall while the sender keeps offering
    hold_out = 1'b1;
    random_phase(20, 1'b0);
    while (!hold_done) @(posedge clk);
    hold_out = 1'b0;

    random_phase(600, 1'b0);
    drain_req = 1'b1;
    while (in_tvalid || expected_q.size() != 0) @(negedge clk);
    drain_req = 1'b0;
    random_phase(80, 1'b1);
    random_phase(600, 1'b0);
    wait_drained();
    stim_done = 1'b1;
    repeat (200) @(posedge clk);
    if (expected_q.size() != 0) report_mismatch("missing results", 0, expected_q.size());

    $display("covered %0d results: %0d allocations, %0d frees, %0d refused, %0d out of memory",
             n_results, n_allocs, n_frees, n_bad, n_oom);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/core/efla_pkg.sv
rtl/core/explicit_free_list_allocator.sv
sim/tb.sv
